### hw/rtl/bsc_pkg.sv
// ---------------------------------------------------------------------------
// bsc_pkg
// Shared types, codes and helpers for the barometric compensation block.
// ---------------------------------------------------------------------------
package bsc_pkg;

    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_NOTEMP = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_MUL,
        S_T_DEN,
        S_T_DIV,
        S_P_CHK,
        S_P_SQ,
        S_P_X1,
        S_P_X2,
        S_P_B3,
        S_P_X3,
        S_P_B4M,
        S_P_B4,
        S_P_B7,
        S_P_DIV,
        S_P_QQ,
        S_P_K1,
        S_P_K2,
        S_P_FIN,
        S_OUT
    } t_state;

    localparam logic [31:0] B6Offset   = 32'd4000;
    localparam logic [31:0] CoefA      = 32'd3038;
    localparam logic [31:0] CoefB      = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] CoefC      = 32'd3791;
    localparam logic [31:0] ScaleBase  = 32'd50000;
    localparam logic [31:0] B4Bias     = 32'd32768;
    localparam logic [19:0] PresMax    = 20'hF_FFFF;

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### hw/rtl/bsc_div.sv
// ---------------------------------------------------------------------------
// bsc_div
// Iterative 32-bit restoring divider, one quotient bit per cycle, optional
// signed operands with truncation toward zero.
// ---------------------------------------------------------------------------
module bsc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_sgn,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= (i_sgn && i_dividend[31]) ? 32'(-i_dividend) : i_dividend;
            r_dvs <= (i_sgn && i_divisor[31]) ? 32'(-i_divisor) : i_divisor;
            r_neg <= i_sgn && (i_dividend[31] ^ i_divisor[31]);
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? 32'(-r_quo) : r_quo;

endmodule

### hw/rtl/barometric_sensor_compensation.sv
// ---------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation over one shared 32-bit
// multiplier and one iterative divider under a small sequencer.
// ---------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | i_in_valid / o_in_stall | req_type, raw_value
//  out     | source    | o_out_valid / i_out_stall | kind, temp, pressure, status
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// Temperature and pressure items wait on the 32-step divider; early status
// results finish sooner.
// One item is in flight: o_in_stall stays high until the result transfers.
// Synchronous active-low reset clears calibration, the stored temperature
// term and the sequencer. The result holds while i_out_stall is high.
// ---------------------------------------------------------------------------
module barometric_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [18:0] i_raw_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic signed [15:0] o_temperature_tenths,
    output logic [19:0] o_pressure_pa,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [bsc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bsc_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
    logic [1:0]  r_oss;
    logic [31:0] r_temp_term;
    logic        r_tt_valid;
    logic        r_kind;
    logic [18:0] r_raw;
    logic [31:0] r_p, r_b6, r_sq, r_x3, r_t, r_b3, r_b4, r_pv;
    logic        r_b7_hi;
    logic signed [15:0] r_temp;
    logic [19:0] r_pres;
    t_status     r_status;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] mul_a, mul_b;
    logic [31:0] x1_t, den, b5, tval, v3, x3_n, b4_n, ppv, pfin;
    logic        div_start, div_sgn, div_done;
    logic [31:0] div_a, div_b, div_q;

    assign ac1 = sx16(r_ac1_ac2[31:16]);
    assign ac2 = sx16(r_ac1_ac2[15:0]);
    assign ac3 = sx16(r_ac3_ac4[31:16]);
    assign ac4 = {16'd0, r_ac3_ac4[15:0]};
    assign ac5 = {16'd0, r_ac5_ac6[31:16]};
    assign ac6 = {16'd0, r_ac5_ac6[15:0]};
    assign b1  = sx16(r_b1_b2[31:16]);
    assign b2  = sx16(r_b1_b2[15:0]);
    assign mc  = sx16(r_mc_md[31:16]);
    assign md  = sx16(r_mc_md[15:0]);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AC1_AC2: r_ac1_ac2 <= i_cfg_data;
                CFG_AC3_AC4: r_ac3_ac4 <= i_cfg_data;
                CFG_AC5_AC6: r_ac5_ac6 <= i_cfg_data;
                CFG_B1_B2:   r_b1_b2   <= i_cfg_data;
                CFG_MC_MD:   r_mc_md   <= i_cfg_data;
                CFG_OSS:     r_oss     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = r_p;
        mul_b = r_p;
        case (r_state)
            S_T_MUL: begin mul_a = {13'd0, r_raw} - ac6; mul_b = ac5; end
            S_P_SQ:  begin mul_a = r_b6;             mul_b = r_b6; end
            S_P_X1:  begin mul_a = b2;               mul_b = asr(r_p, 12); end
            S_P_X2:  begin mul_a = ac2;              mul_b = r_b6; end
            S_P_B3:  begin mul_a = ac3;              mul_b = r_b6; end
            S_P_X3:  begin mul_a = b1;               mul_b = r_sq; end
            S_P_B4M: begin mul_a = ac4;              mul_b = x3_n + B4Bias; end
            S_P_B4:  begin mul_a = {13'd0, r_raw} - r_b3; mul_b = ScaleBase >> r_oss; end
            S_P_QQ:  begin mul_a = asr(r_pv, 8);     mul_b = asr(r_pv, 8); end
            S_P_K1:  begin mul_a = r_p;              mul_b = CoefA; end
            S_P_K2:  begin mul_a = CoefB;            mul_b = r_pv; end
            default: ;
        endcase
    end

    always_comb begin
        x1_t = asr(r_p, 15);
        den  = x1_t + md;
        b5   = r_x3 + div_q;
        tval = asr(b5 + 32'd8, 4);
        v3   = 32'((((ac1 << 2) + r_x3) << r_oss) + 32'd2);
        x3_n = asr(r_t + asr(r_p, 16) + 32'd2, 2);
        b4_n = r_p >> 15;
        ppv  = r_b7_hi ? {div_q[30:0], 1'b0} : div_q;
        pfin = r_pv + asr(r_t + asr(r_p, 16) + CoefC, 4);
        div_start = 1'b0;
        div_sgn   = 1'b0;
        div_a     = r_p;
        div_b     = r_b4;
        if (r_state == S_T_DEN) begin
            div_start = (den != 32'd0);
            div_sgn   = 1'b1;
            div_a     = mc << 11;
            div_b     = den;
        end else if (r_state == S_P_B7) begin
            div_start = 1'b1;
            div_a     = r_p[31] ? r_p : {r_p[30:0], 1'b0};
        end
    end

    bsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_sgn      (div_sgn),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = i_req_type ? S_P_CHK : S_T_MUL;
            S_T_MUL: n_state = S_T_DEN;
            S_T_DEN: n_state = (den == 32'd0) ? S_OUT : S_T_DIV;
            S_T_DIV: if (div_done) n_state = S_OUT;
            S_P_CHK: n_state = r_tt_valid ? S_P_SQ : S_OUT;
            S_P_SQ:  n_state = S_P_X1;
            S_P_X1:  n_state = S_P_X2;
            S_P_X2:  n_state = S_P_B3;
            S_P_B3:  n_state = S_P_X3;
            S_P_X3:  n_state = S_P_B4M;
            S_P_B4M: n_state = S_P_B4;
            S_P_B4:  n_state = (b4_n == 32'd0) ? S_OUT : S_P_B7;
            S_P_B7:  n_state = S_P_DIV;
            S_P_DIV: if (div_done) n_state = S_P_QQ;
            S_P_QQ:  n_state = S_P_K1;
            S_P_K1:  n_state = S_P_K2;
            S_P_K2:  n_state = S_P_FIN;
            S_P_FIN: n_state = S_OUT;
            S_OUT:   if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_term <= '0;
            r_tt_valid  <= 1'b0;
        end else if (r_state == S_T_DEN && den == 32'd0) begin
            r_tt_valid <= 1'b0;
        end else if (r_state == S_T_DIV && div_done) begin
            r_temp_term <= b5;
            r_tt_valid  <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p <= 32'(mul_a * mul_b);
        case (r_state)
            S_IDLE: begin
                r_kind   <= i_req_type;
                r_raw    <= i_raw_value;
                r_temp   <= '0;
                r_pres   <= '0;
                r_status <= ST_OK;
            end
            S_T_DEN: begin
                r_x3 <= x1_t;
                if (den == 32'd0) r_status <= ST_DIV0;
            end
            S_T_DIV: begin
                if (div_done) begin
                    if ($signed(tval) > 32'sd32767) begin
                        r_temp   <= 16'sd32767;
                        r_status <= ST_SAT;
                    end else if ($signed(tval) < -32'sd32768) begin
                        r_temp   <= -16'sd32768;
                        r_status <= ST_SAT;
                    end else begin
                        r_temp <= tval[15:0];
                    end
                end
            end
            S_P_CHK: begin
                r_b6 <= r_temp_term - B6Offset;
                if (!r_tt_valid) r_status <= ST_NOTEMP;
            end
            S_P_X1:  r_sq <= asr(r_p, 12);
            S_P_X2:  r_x3 <= asr(r_p, 11);
            S_P_B3:  r_x3 <= r_x3 + asr(r_p, 11);
            S_P_X3: begin
                r_b3 <= v3[31] ? asr(v3 + 32'd3, 2) : asr(v3, 2);
                r_t  <= asr(r_p, 13);
            end
            S_P_B4M: r_x3 <= x3_n;
            S_P_B4: begin
                r_b4 <= b4_n;
                if (b4_n == 32'd0) r_status <= ST_DIV0;
            end
            S_P_B7:  r_b7_hi <= r_p[31];
            S_P_DIV: r_pv <= ppv;
            S_P_K2:  r_t <= asr(r_p, 16);
            S_P_FIN: begin
                if (pfin[31]) begin
                    r_pres   <= '0;
                    r_status <= ST_SAT;
                end else if (pfin[30:20] != 11'd0) begin
                    r_pres   <= PresMax;
                    r_status <= ST_SAT;
                end else begin
                    r_pres <= pfin[19:0];
                end
            end
            default: ;
        endcase
    end

    assign o_result_kind        = r_kind;
    assign o_temperature_tenths = r_temp;
    assign o_pressure_pa        = r_pres;
    assign o_status             = r_status;

endmodule
